// ----- hdl/hlbs_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hlbs_pkg
// Shared types and constants of the hysteresis LED bar status unit.
// -----------------------------------------------------------------------------
package hlbs_pkg;

   localparam int TEMP_W     = 12;
   localparam int MODE_W     = 3;
   localparam int MARGIN_W   = 8;
   localparam int INTERVAL_W = 16;
   localparam int LEVEL_W    = 3;
   localparam int PATTERN_W  = 8;
   // threshold +/- margin, no overflow possible
   localparam int SUM_W      = TEMP_W + 2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_ONE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_TWO   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_THREE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MARGIN      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTERVAL    = 3'd4;

   localparam logic [LEVEL_W-1:0] LEVEL_UNSET = 3'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_1     = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_2     = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_3     = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_4     = 3'd4;

   localparam logic [PATTERN_W-1:0] BAR_LEVEL_1 = 8'b0000_0000;
   localparam logic [PATTERN_W-1:0] BAR_LEVEL_2 = 8'b1000_0000;
   localparam logic [PATTERN_W-1:0] BAR_LEVEL_3 = 8'b1100_0000;
   localparam logic [PATTERN_W-1:0] BAR_LEVEL_4 = 8'b1110_0000;

   localparam logic [MODE_W-1:0] MODE_LAST_LIT = 3'd2;

   typedef struct packed {
      logic signed [TEMP_W-1:0]  thr_one;
      logic signed [TEMP_W-1:0]  thr_two;
      logic signed [TEMP_W-1:0]  thr_three;
      logic [MARGIN_W-1:0]       margin;
      logic [INTERVAL_W-1:0]     interval;
   } cfg_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_difference;
      logic [MODE_W-1:0]        display_mode;
      logic                     pump_fault;
      logic                     general_fault;
   } item_type;

endpackage

// ----- hdl/hysteresis_led_bar_status_unit.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hysteresis_led_bar_status_unit
// Temperature-difference LED bar with hysteresis, mode/fault LEDs and refresh.
// -----------------------------------------------------------------------------
// Takes one update word per cycle while rsp_ is not stalled and returns one
// result word per update. A word accepted on req_ lands in an input register;
// from there the level sort, hysteresis step, LED byte and refresh decision
// are evaluated and written to the result register when it is free or
// draining, and the result register presents the result word on rsp_.
// Throughput is one word per clock while rsp_ is not stalled, limited only by
// the single input register and the result register; the held level,
// previous pattern and repeat counter update in the same cycle the result is
// written, so consecutive words see each other's state with no bubble.
// Backpressure on rsp_ holds the result register and then the input
// register. Configuration writes take effect the cycle after csr_we and are
// expected only while no update is in flight.
module hysteresis_led_bar_status_unit (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata, low bit up: temp_difference[11:0], display_mode[14:12],
   // pump_fault[15], general_fault[16], zero fill [23:17]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [hlbs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata, low bit up: led_pattern[7:0], shown_level[10:8],
   // refresh[11], zero fill [15:12]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [hlbs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register write port
   input  logic                               csr_we,
   input  logic [hlbs_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [hlbs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hlbs_pkg::*;

   cfg_type              cfg_ff;
   logic                 s1_valid_ff;
   item_type             s1_item_ff;
   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                 advance;
   logic                 step;
   logic [LEVEL_W-1:0]   level;
   logic [PATTERN_W-1:0] pattern;
   logic                 refresh;

   // result register free or draining this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr_one   <= 12'sd32;
         cfg_ff.thr_two   <= 12'sd96;
         cfg_ff.thr_three <= 12'sd160;
         cfg_ff.margin    <= 8'd8;
         cfg_ff.interval  <= 16'd10;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LEVEL_ONE:   cfg_ff.thr_one   <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_LEVEL_TWO:   cfg_ff.thr_two   <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_LEVEL_THREE: cfg_ff.thr_three <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_MARGIN:      cfg_ff.margin    <= csr_wdata[MARGIN_W-1:0];
            CSR_INTERVAL:    cfg_ff.interval  <= csr_wdata[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff.temp_difference <= $signed(req_tdata[11:0]);
         s1_item_ff.display_mode    <= req_tdata[14:12];
         s1_item_ff.pump_fault      <= req_tdata[15];
         s1_item_ff.general_fault   <= req_tdata[16];
      end
   end

   hlbs_level u_level (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .temp_difference (s1_item_ff.temp_difference),
      .cfg             (cfg_ff),
      .level_in        (level)
   );

   hlbs_pattern u_pattern (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .level         (level),
      .display_mode  (s1_item_ff.display_mode),
      .pump_fault    (s1_item_ff.pump_fault),
      .general_fault (s1_item_ff.general_fault),
      .interval      (cfg_ff.interval),
      .pattern       (pattern),
      .refresh       (refresh)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {4'b0, refresh, level, pattern};
      end
   end

endmodule

// ----- hdl/hlbs_level.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hlbs_level
// Plain level sort and held level with hysteresis, one step per word.
// -----------------------------------------------------------------------------
module hlbs_level (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic signed [hlbs_pkg::TEMP_W-1:0]   temp_difference,
   input  hlbs_pkg::cfg_type                    cfg,
   output logic [hlbs_pkg::LEVEL_W-1:0]         level_in
);
   import hlbs_pkg::*;

   logic [LEVEL_W-1:0]      held_ff;
   logic [LEVEL_W-1:0]      plain;
   logic [LEVEL_W-1:0]      cur;
   logic signed [SUM_W-1:0] t_ext;
   logic signed [SUM_W-1:0] m_ext;
   logic signed [SUM_W-1:0] one_up, one_dn, two_up, two_dn, three_up, three_dn;

   always_comb begin
      t_ext    = SUM_W'(temp_difference);
      m_ext    = $signed({{(SUM_W-MARGIN_W){1'b0}}, cfg.margin});
      one_up   = SUM_W'(cfg.thr_one) + m_ext;
      one_dn   = SUM_W'(cfg.thr_one) - m_ext;
      two_up   = SUM_W'(cfg.thr_two) + m_ext;
      two_dn   = SUM_W'(cfg.thr_two) - m_ext;
      three_up = SUM_W'(cfg.thr_three) + m_ext;
      three_dn = SUM_W'(cfg.thr_three) - m_ext;

      if (temp_difference < cfg.thr_one) begin
         plain = LEVEL_1;
      end else if (temp_difference < cfg.thr_two) begin
         plain = LEVEL_2;
      end else if (temp_difference < cfg.thr_three) begin
         plain = LEVEL_3;
      end else begin
         plain = LEVEL_4;
      end

      cur      = (held_ff == LEVEL_UNSET) ? plain : held_ff;
      level_in = cur;
      if (cur != plain) begin
         case (cur)
            LEVEL_1: begin
               if (t_ext > one_up) level_in = LEVEL_2;
            end
            LEVEL_2: begin
               // down wins when both hold
               if (t_ext < one_dn) level_in = LEVEL_1;
               else if (t_ext > two_up) level_in = LEVEL_3;
            end
            LEVEL_3: begin
               if (t_ext < two_dn) level_in = LEVEL_2;
               else if (t_ext > three_up) level_in = LEVEL_4;
            end
            default: begin
               if (t_ext < three_dn) level_in = LEVEL_3;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= LEVEL_UNSET;
      end else if (step) begin
         held_ff <= level_in;
      end
   end

endmodule

// ----- hdl/hlbs_pattern.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hlbs_pattern
// LED byte build and refresh request with the repeat counter.
// -----------------------------------------------------------------------------
module hlbs_pattern (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [hlbs_pkg::LEVEL_W-1:0]         level,
   input  logic [hlbs_pkg::MODE_W-1:0]          display_mode,
   input  logic                                 pump_fault,
   input  logic                                 general_fault,
   input  logic [hlbs_pkg::INTERVAL_W-1:0]      interval,
   output logic [hlbs_pkg::PATTERN_W-1:0]       pattern,
   output logic                                 refresh
);
   import hlbs_pkg::*;

   logic [PATTERN_W-1:0]  prev_ff;
   logic [INTERVAL_W-1:0] count_ff;
   logic [INTERVAL_W-1:0] count_in;
   logic [INTERVAL_W-1:0] count_inc;
   logic [PATTERN_W-1:0]  bar;
   logic [PATTERN_W-1:0]  mode_led;

   always_comb begin
      case (level)
         LEVEL_1: bar = BAR_LEVEL_1;
         LEVEL_2: bar = BAR_LEVEL_2;
         LEVEL_3: bar = BAR_LEVEL_3;
         default: bar = BAR_LEVEL_4;
      endcase
      mode_led = '0;
      if (display_mode <= MODE_LAST_LIT) begin
         mode_led[3'd2 + display_mode] = 1'b1;
      end
      pattern = bar | mode_led | {6'b0, general_fault, pump_fault};

      count_inc = count_ff + 1'b1;
      if (pattern != prev_ff) begin
         count_in = '0;
         refresh  = 1'b1;
      end else if (count_inc >= interval) begin
         count_in = '0;
         refresh  = 1'b1;
      end else begin
         count_in = count_inc;
         refresh  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         count_ff <= '0;
      end else if (step) begin
         prev_ff  <= pattern;
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/hlbs_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hlbs_checker
// Port-level checks of the status unit, bound to the top level.
// -----------------------------------------------------------------------------
module hlbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // held level always loaded and in range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:8] == 3'd1 || rsp_tdata[10:8] == 3'd2 ||
                      rsp_tdata[10:8] == 3'd3 || rsp_tdata[10:8] == 3'd4))
      else $error("shown level out of range");

   // bar LEDs match the shown level
   a_bar_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($countones(rsp_tdata[7:5]) == int'(rsp_tdata[10:8]) - 1 &&
                      (rsp_tdata[7:5] == 3'b000 || rsp_tdata[7:5] == 3'b100 ||
                       rsp_tdata[7:5] == 3'b110 || rsp_tdata[7:5] == 3'b111)))
      else $error("bar LEDs disagree with shown level");

   // at most one mode LED
   a_mode_led: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[4:2]))
      else $error("more than one mode LED lit");

endmodule

bind hysteresis_led_bar_status_unit hlbs_checker u_hlbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
